[sv/imh_pkg.sv]
// Package with the types, constants and codes of the indexed min-heap.
`default_nettype none
package imh_pkg;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned PosW      = 6;
  localparam int unsigned CountW    = 7;
  localparam int unsigned KeyW      = 32;
  localparam int unsigned HandleW   = 6;
  localparam int unsigned Handles   = 64;
  localparam int unsigned PaddrW    = 3;

  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_UPDATE  = 2'd1;
  localparam logic [1:0] KIND_EXTRACT = 2'd2;
  localparam logic [1:0] KIND_NOP     = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_EMPTY  = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_DUP    = 3'd4;

  localparam logic [PaddrW-1:0] REG_CAP_LIMIT = 3'd0;

  typedef struct packed {
    logic [1:0]         kind;
    logic [HandleW-1:0] item_handle;
    logic [KeyW-1:0]    item_key;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [HandleW-1:0] out_handle;
    logic [KeyW-1:0]    out_key;
    logic [CountW-1:0]  count_after;
  } out_item_t;

endpackage
`default_nettype wire

[sv/indexed_min_heap.sv]
// Top level of the indexed binary min-heap priority queue.
`default_nettype none
// Indexed min-heap: holds up to 64 (key, handle) entries in an array binary
// min-heap with a handle-to-position table. Each input item is an insert, a
// key update of a present handle, or an extract-min, and each gives exactly
// one result item with status, the extracted or current minimum, and the
// count. The block works on one item at a time and is not ready meanwhile.
// All heap arrays live in one-read-port memories, and a single key
// comparator is reused by a small sequencer: a sift-up level reads the
// parent, compares and swaps; a sift-down level reads the left child, then
// the right child if there is one, compares and swaps. When a sift stops,
// the root is read again for the result. The result sits in an output
// register; the next item is accepted in the cycle after it has been
// taken. The user must write the limit register over the APB-style port
// only while the block is idle; the block itself does not enforce this.
// Heap memories need no clearing; reset clears the count and the 64
// handle present flags.
module indexed_min_heap import imh_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_item_t          in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_item_t              out_item_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_UPRD  = 4'd2;  // read parent of pos
  localparam logic [3:0] S_UPCMP = 4'd3;
  localparam logic [3:0] S_DNRL  = 4'd4;  // read left child
  localparam logic [3:0] S_DNRR  = 4'd5;  // read right child
  localparam logic [3:0] S_DNCMP = 4'd6;
  localparam logic [3:0] S_SWAP  = 4'd7;  // write second half of a swap
  localparam logic [3:0] S_ROOT  = 4'd8;  // read root for result
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_EXLR  = 4'd10; // read last entry for extract
  localparam logic [3:0] S_EXWR  = 4'd11;
  localparam logic [3:0] S_POSRD = 4'd12;
  localparam logic [3:0] S_UPWR  = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  // Memories.
  logic [KeyW-1:0]    key_mem [Capacity];
  logic [HandleW-1:0] hnd_mem [Capacity];
  logic [PosW-1:0]    pos_mem [Handles];
  logic [Handles-1:0] present_q, present_d;

  logic [3:0]         state_q, state_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [CountW-1:0]  limit_q;
  in_item_t           item_q, item_d;
  logic [2:0]         status_q, status_d;
  logic               taken_q, taken_d;
  logic               down_after_q, down_after_d; // update: sift down after up
  logic               up_moved_q, up_moved_d;
  logic [PosW-1:0]    pos_q, pos_d;         // current sift position
  logic [KeyW-1:0]    cur_key_q, cur_key_d; // key/handle of the moving entry
  logic [HandleW-1:0] cur_hnd_q, cur_hnd_d;
  logic [PosW-1:0]    oth_pos_q, oth_pos_d; // partner position
  logic [KeyW-1:0]    oth_key_q, oth_key_d;
  logic [HandleW-1:0] oth_hnd_q, oth_hnd_d;
  logic               have_l_q, have_l_d;
  out_item_t          res_q, res_d;
  logic               out_valid_q, out_valid_d;

  // Memory ports: one read address and one write per array per cycle.
  logic [PosW-1:0]    rd_addr;
  logic [KeyW-1:0]    rd_key_q;
  logic [HandleW-1:0] rd_hnd_q;
  logic [HandleW-1:0] prd_addr;
  logic [PosW-1:0]    prd_q;
  logic               hw_en;
  logic [PosW-1:0]    hw_addr;
  logic [KeyW-1:0]    hw_key;
  logic [HandleW-1:0] hw_hnd;
  logic               pw_en;
  logic [HandleW-1:0] pw_addr;
  logic [PosW-1:0]    pw_data;

  always_ff @(posedge clk_i) begin
    if (hw_en) begin
      key_mem[hw_addr] <= hw_key;
      hnd_mem[hw_addr] <= hw_hnd;
    end
    if (pw_en) begin
      pos_mem[pw_addr] <= pw_data;
    end
    rd_key_q <= key_mem[rd_addr];
    rd_hnd_q <= hnd_mem[rd_addr];
    prd_q    <= pos_mem[prd_addr];
  end

  // The shared key comparator: strictly less-than.
  logic [KeyW-1:0] cmp_a, cmp_b;
  logic            cmp_lt;
  assign cmp_lt = cmp_a < cmp_b;

  logic [CountW-1:0] lim_eff;
  assign lim_eff = (limit_q > CountW'(Capacity)) ? CountW'(Capacity) : limit_q;

  logic [CountW:0] lidx, ridx;
  assign lidx = {1'b0, pos_q, 1'b0} + (CountW+1)'(1);
  assign ridx = {1'b0, pos_q, 1'b0} + (CountW+1)'(2);
  logic [PosW-1:0] parent;
  assign parent = (pos_q - PosW'(1)) >> 1;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr == REG_CAP_LIMIT) ? {25'd0, limit_q} : 32'd0;

  always_comb begin
    state_d = state_q; count_d = count_q; item_d = item_q;
    status_d = status_q; taken_d = taken_q; down_after_d = down_after_q;
    up_moved_d = up_moved_q;
    pos_d = pos_q; cur_key_d = cur_key_q; cur_hnd_d = cur_hnd_q;
    oth_pos_d = oth_pos_q; oth_key_d = oth_key_q; oth_hnd_d = oth_hnd_q;
    have_l_d = have_l_q; res_d = res_q; out_valid_d = out_valid_q;
    present_d = present_q;
    rd_addr = '0; prd_addr = item_q.item_handle;
    hw_en = 1'b0; hw_addr = pos_q; hw_key = cur_key_q; hw_hnd = cur_hnd_q;
    pw_en = 1'b0; pw_addr = cur_hnd_q; pw_data = pos_q;
    cmp_a = cur_key_q; cmp_b = oth_key_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          item_d = in_item_i;
          status_d = ST_OK; taken_d = 1'b0; down_after_d = 1'b0;
          up_moved_d = 1'b0;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        prd_addr = item_q.item_handle;
        state_d = S_ROOT;
        case (item_q.kind)
          KIND_INSERT: begin
            if (present_q[item_q.item_handle]) begin
              status_d = ST_DUP;
            end else if (count_q >= lim_eff) begin
              status_d = ST_FULL;
            end else begin
              hw_en = 1'b1; hw_addr = count_q[PosW-1:0];
              hw_key = item_q.item_key; hw_hnd = item_q.item_handle;
              pw_en = 1'b1; pw_addr = item_q.item_handle;
              pw_data = count_q[PosW-1:0];
              present_d[item_q.item_handle] = 1'b1;
              count_d = count_q + CountW'(1);
              pos_d = count_q[PosW-1:0];
              cur_key_d = item_q.item_key; cur_hnd_d = item_q.item_handle;
              state_d = S_UPRD;
            end
          end
          KIND_UPDATE: begin
            if (!present_q[item_q.item_handle]) begin
              status_d = ST_ABSENT;
            end else begin
              state_d = S_POSRD;
            end
          end
          KIND_EXTRACT: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              rd_addr = '0;
              state_d = S_EXLR;
            end
          end
          default: ;
        endcase
      end
      S_POSRD: begin
        state_d = S_UPWR;
      end
      S_UPWR: begin
        // Write the new key at the handle's position, then sift up, and down if it did not move up.
        pos_d = prd_q; cur_key_d = item_q.item_key;
        cur_hnd_d = item_q.item_handle;
        hw_en = 1'b1; hw_addr = prd_q; hw_key = item_q.item_key;
        hw_hnd = item_q.item_handle;
        down_after_d = 1'b1;
        state_d = S_UPRD;
      end
      S_EXLR: begin
        // Root is in the read register; fetch the last entry.
        res_d.out_handle = rd_hnd_q; res_d.out_key = rd_key_q;
        present_d[rd_hnd_q] = 1'b0;
        taken_d = 1'b1;
        rd_addr = PosW'(count_q - CountW'(1));
        count_d = count_q - CountW'(1);
        state_d = S_EXWR;
      end
      S_EXWR: begin
        // Move the last entry to the root and sift it down.
        cur_key_d = rd_key_q; cur_hnd_d = rd_hnd_q; pos_d = '0;
        hw_en = 1'b1; hw_addr = '0; hw_key = rd_key_q; hw_hnd = rd_hnd_q;
        pw_en = 1'b1; pw_addr = rd_hnd_q; pw_data = '0;
        state_d = (count_q == '0) ? S_ROOT : S_DNRL;
      end
      S_UPRD: begin
        if (pos_q == '0) begin
          state_d = down_after_q ? S_DNRL : S_ROOT;
        end else begin
          rd_addr = parent; oth_pos_d = parent;
          state_d = S_UPCMP;
        end
      end
      S_UPCMP: begin
        cmp_a = cur_key_q; cmp_b = rd_key_q;
        if (cmp_lt) begin
          // Parent moves down to pos; moving entry goes to parent.
          hw_en = 1'b1; hw_addr = pos_q; hw_key = rd_key_q; hw_hnd = rd_hnd_q;
          pw_en = 1'b1; pw_addr = rd_hnd_q; pw_data = pos_q;
          pos_d = oth_pos_q;
          up_moved_d = 1'b1;
          state_d = S_SWAP;
        end else begin
          state_d = down_after_q ? S_DNRL : S_ROOT;
        end
      end
      S_SWAP: begin
        hw_en = 1'b1; hw_addr = pos_q;
        pw_en = 1'b1; pw_addr = cur_hnd_q; pw_data = pos_q;
        state_d = up_moved_q ? S_UPRD : S_DNRL;
      end
      S_DNRL: begin
        // An update that already moved up needs no sift-down.
        up_moved_d = 1'b0;
        if (down_after_q && up_moved_q) begin
          state_d = S_ROOT;
        end else if (lidx >= {1'b0, count_q}) begin
          state_d = S_ROOT;
        end else begin
          rd_addr = lidx[PosW-1:0];
          oth_pos_d = lidx[PosW-1:0]; oth_key_d = cur_key_q;
          have_l_d = 1'b0;
          state_d = S_DNRR;
        end
      end
      S_DNRR: begin
        // Left child: keep it as best if strictly smaller than the entry.
        cmp_a = rd_key_q; cmp_b = cur_key_q;
        have_l_d = cmp_lt;
        oth_key_d = cmp_lt ? rd_key_q : cur_key_q;
        oth_hnd_d = rd_hnd_q;
        if (ridx < {1'b0, count_q}) begin
          rd_addr = ridx[PosW-1:0];
          state_d = S_DNCMP;
        end else begin
          state_d = cmp_lt ? S_DNCMP : S_ROOT;
          if (!cmp_lt) state_d = S_ROOT;
          else begin
            // No right child; swap with left now.
            hw_en = 1'b1; hw_addr = pos_q; hw_key = rd_key_q; hw_hnd = rd_hnd_q;
            pw_en = 1'b1; pw_addr = rd_hnd_q; pw_data = pos_q;
            pos_d = lidx[PosW-1:0];
            state_d = S_SWAP;
          end
        end
      end
      S_DNCMP: begin
        // Right child against the best so far.
        cmp_a = rd_key_q; cmp_b = oth_key_q;
        if (cmp_lt) begin
          hw_en = 1'b1; hw_addr = pos_q; hw_key = rd_key_q; hw_hnd = rd_hnd_q;
          pw_en = 1'b1; pw_addr = rd_hnd_q; pw_data = pos_q;
          pos_d = ridx[PosW-1:0];
          state_d = S_SWAP;
        end else if (have_l_q) begin
          hw_en = 1'b1; hw_addr = pos_q; hw_key = oth_key_q; hw_hnd = oth_hnd_q;
          pw_en = 1'b1; pw_addr = oth_hnd_q; pw_data = pos_q;
          pos_d = oth_pos_q;
          state_d = S_SWAP;
        end else begin
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        rd_addr = '0;
        state_d = S_FIN;
      end
      S_FIN: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        res_d.status = status_q;
        res_d.count_after = count_q;
        if (!taken_q) begin
          res_d.out_handle = (count_q == '0) ? '0 : rd_hnd_q;
          res_d.out_key    = (count_q == '0) ? '0 : rd_key_q;
        end
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      limit_q <= CountW'(Capacity);
      present_q <= '0;
      out_valid_q <= 1'b0;
      up_moved_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      present_q <= present_d;
      out_valid_q <= out_valid_d;
      up_moved_q <= up_moved_d;
      if (psel && penable && pwrite && paddr == REG_CAP_LIMIT) begin
        limit_q <= pwdata[CountW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d; status_q <= status_d; taken_q <= taken_d;
    down_after_q <= down_after_d; pos_q <= pos_d;
    cur_key_q <= cur_key_d; cur_hnd_q <= cur_hnd_d;
    oth_pos_q <= oth_pos_d; oth_key_q <= oth_key_d; oth_hnd_q <= oth_hnd_d;
    have_l_q <= have_l_d; res_q <= res_d;
  end

endmodule
`default_nettype wire

[sv/imh_checker.sv]
// Port-level checker for the indexed min-heap, bound to the top level.
`default_nettype none
module imh_checker import imh_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_o
);
  // No new item is taken while a result waits.
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while result pending");
  // An accepted item makes the block busy next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("ready after accept");
  // Count never exceeds the heap size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.count_after <= 7'd64) else $error("count too large");
  // An empty result carries no entry.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_EMPTY) |->
      (out_item_o.out_key == '0 && out_item_o.count_after == '0))
    else $error("empty result not zero");
endmodule

bind indexed_min_heap imh_checker u_imh_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
);
`default_nettype wire
